// ----- src/rsa_pkg.sv -----
// Shared types and constants for the exponent pair search.
`timescale 1ns / 1ps
package rsa_pkg;
	localparam int WordBitsDef = 64;
	localparam int CandCountDef = 9;
	localparam int TableSize = 9;

	localparam logic [1:0] ST_FOUND = 2'd0;
	localparam logic [1:0] ST_SMALL = 2'd1;
	localparam logic [1:0] ST_NONE  = 2'd2;

	function automatic logic [16:0] exp_table(input logic [3:0] idx);
		logic [16:0] v;
		case (idx)
			4'd0: v = 17'd3;
			4'd1: v = 17'd5;
			4'd2: v = 17'd7;
			4'd3: v = 17'd11;
			4'd4: v = 17'd13;
			4'd5: v = 17'd17;
			4'd6: v = 17'd19;
			4'd7: v = 17'd257;
			default: v = 17'd65537;
		endcase
		return v;
	endfunction

	// datapath commands
	typedef enum logic [3:0] {
		CMD_NONE, CMD_LOAD, CMD_CAND, CMD_DIV, CMD_QMUL, CMD_STEP, CMD_MUL, CMD_MOD,
		CMD_BITS
	} cmd_t;

	typedef struct packed {
		logic phi_lt_e;
		logic div_done;
		logic mul_done;
		logic rem_zero;
		logic accept;
		logic bits_done;
	} dp_status_t;
endpackage

// ----- src/rsa_divider.sv -----
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module rsa_divider import rsa_pkg::*; #(
	parameter int WordBits = WordBitsDef
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [WordBits-1:0] dividend,
	input  logic [WordBits-1:0] divisor,
	output logic                done,
	output logic [WordBits-1:0] quotient,
	output logic [WordBits-1:0] remainder
);
	localparam int CntW = $clog2(WordBits + 1);
	logic [WordBits-1:0] quo_q, rem_q, dvs_q;
	logic [CntW-1:0] cnt_q;
	logic busy_q;
	logic [WordBits:0] trial;

	assign trial = {rem_q, quo_q[WordBits-1]} - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CntW'(WordBits);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CntW'(1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!trial[WordBits]) begin
				rem_q <= trial[WordBits-1:0];
				quo_q <= {quo_q[WordBits-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[WordBits-2:0], quo_q[WordBits-1]};
				quo_q <= {quo_q[WordBits-2:0], 1'b0};
			end
		end
	end

	assign quotient = quo_q;
	assign remainder = rem_q;
endmodule

// ----- src/rsa_datapath.sv -----
// Euclid registers, multiplier check and bit length counting.
`timescale 1ns / 1ps
module rsa_datapath import rsa_pkg::*; #(
	parameter int WordBits = WordBitsDef
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cmd_t                cmd,
	input  logic [3:0]          cand_idx,
	input  logic [63:0]         phi_in,
	output dp_status_t          stat,
	output logic [16:0]         e_out,
	output logic [WordBits-1:0] d_out,
	output logic [4:0]          e_bits,
	output logic [6:0]          d_bits
);
	localparam int Digits = (WordBits + 15) / 16;
	localparam int MCntW = $clog2(Digits + 1);
	logic [WordBits-1:0] phi_q, a_q, b_q, s0_q, s1_q;
	logic [16:0] e_q;
	logic [WordBits-1:0] e_w, quo, rem, div_a, div_b;
	logic div_start;
	logic [WordBits-1:0] bshift_q;
	logic [6:0] bcnt_q;
	// multiplier over 16-bit digits of the second operand, low word kept
	logic [WordBits-1:0] mx_q, my_q, macc_q, mul_x, mul_y;
	logic [MCntW-1:0] mcnt_q;
	logic mbusy_q, mdone_q, mul_start;
	logic [WordBits+15:0] mpart;

	assign e_w = WordBits'(e_q);

	always_comb begin
		div_start = (cmd == CMD_DIV) || (cmd == CMD_MOD);
		div_a = (cmd == CMD_MOD) ? macc_q : a_q;
		div_b = (cmd == CMD_MOD) ? phi_q : b_q;
		mul_start = (cmd == CMD_QMUL) || (cmd == CMD_MUL);
		mul_x = (cmd == CMD_MUL) ? s0_q : s1_q;
		mul_y = (cmd == CMD_MUL) ? e_w : quo;
	end

	rsa_divider #(.WordBits(WordBits)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend(div_a), .divisor(div_b),
		.done(stat.div_done), .quotient(quo), .remainder(rem)
	);

	assign mpart = {16'd0, mx_q} * {{WordBits{1'b0}}, my_q[15:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mbusy_q <= 1'b0;
			mdone_q <= 1'b0;
			mcnt_q <= '0;
		end else begin
			mdone_q <= 1'b0;
			if (mul_start) begin
				mbusy_q <= 1'b1;
				mcnt_q <= MCntW'(Digits);
			end else if (mbusy_q) begin
				mcnt_q <= mcnt_q - 1'b1;
				if (mcnt_q == MCntW'(1)) begin
					mbusy_q <= 1'b0;
					mdone_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mul_start) begin
			mx_q <= mul_x;
			my_q <= mul_y;
			macc_q <= '0;
		end else if (mbusy_q) begin
			macc_q <= macc_q + mpart[WordBits-1:0];
			mx_q <= mx_q << 16;
			my_q <= my_q >> 16;
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd)
			CMD_LOAD: phi_q <= phi_in[WordBits-1:0];
			CMD_CAND: begin
				e_q <= exp_table(cand_idx);
				a_q <= phi_q;
				b_q <= WordBits'(exp_table(cand_idx));
				s0_q <= '0;
				s1_q <= WordBits'(1);
			end
			CMD_STEP: begin
				a_q <= b_q;
				b_q <= rem;
				s0_q <= s1_q;
				// product holds quotient times s1, wrapped
				s1_q <= s0_q - macc_q;
			end
			CMD_BITS: begin
				bshift_q <= s0_q;
				bcnt_q <= '0;
			end
			default: begin
				if (bshift_q != '0) begin
					bshift_q <= bshift_q >> 1;
					bcnt_q <= bcnt_q + 1'b1;
				end
			end
		endcase
	end

	// after the last CMD_STEP (remainder zero), a_q is gcd and s0_q the coefficient
	assign stat.phi_lt_e = phi_q < e_w;
	assign stat.mul_done = mdone_q;
	assign stat.rem_zero = rem == '0;
	assign stat.accept = (a_q == WordBits'(1)) && (e_w < phi_q) &&
		(rem == WordBits'(1)) && (s0_q != e_w);
	assign stat.bits_done = bshift_q == '0;

	assign e_out = e_q;
	assign d_out = s0_q;
	assign d_bits = bcnt_q;
	always_comb begin
		e_bits = 5'd0;
		for (int i = 0; i < 17; i++)
			if (e_q[i]) e_bits = 5'(i + 1);
	end
endmodule

// ----- src/rsa_ctrl.sv -----
// Sequencer over candidates and Euclid steps, with the output register.
`timescale 1ns / 1ps
module rsa_ctrl import rsa_pkg::*; #(
	parameter int WordBits = WordBitsDef,
	parameter int CandCount = CandCountDef
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                out_ready,
	output logic                out_valid,
	output logic [95:0]         out_data,
	output cmd_t                cmd,
	output logic [3:0]          cand_idx,
	input  dp_status_t          stat,
	input  logic [16:0]         e_val,
	input  logic [WordBits-1:0] d_val,
	input  logic [4:0]          e_bits,
	input  logic [6:0]          d_bits
);
	typedef enum logic [3:0] {
		S_IDLE, S_CAND, S_CHECK, S_DIVW, S_QMULW, S_MULW, S_PRODW, S_MODW, S_BITW,
		S_OUT
	} state_t;
	state_t state_q;
	logic [3:0] idx_q;
	logic div_pend_q;

	assign in_ready = (state_q == S_IDLE);
	assign cand_idx = idx_q;

	always_comb begin
		cmd = CMD_NONE;
		unique case (state_q)
			S_IDLE: if (in_valid) cmd = CMD_LOAD;
			S_CAND: cmd = CMD_CAND;
			S_CHECK: if (!stat.phi_lt_e) cmd = CMD_DIV;
			S_DIVW: begin
				if (stat.div_done) cmd = CMD_QMUL;
				else if (div_pend_q) cmd = CMD_DIV;
			end
			S_QMULW: if (stat.mul_done) cmd = CMD_STEP;
			S_MULW: cmd = CMD_MUL;
			S_PRODW: if (stat.mul_done) cmd = CMD_MOD;
			S_MODW: if (stat.div_done && stat.accept) cmd = CMD_BITS;
			default: cmd = CMD_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q <= '0;
			out_valid <= 1'b0;
			out_data <= '0;
			div_pend_q <= 1'b0;
		end else begin
			div_pend_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (in_valid) begin
					idx_q <= '0;
					state_q <= S_CAND;
				end
				S_CAND: state_q <= S_CHECK;
				S_CHECK: begin
					if (stat.phi_lt_e) begin
						out_data <= {32'd0, 64'd0} | 96'(ST_SMALL);
						out_valid <= 1'b1;
						state_q <= S_OUT;
					end else state_q <= S_DIVW;
				end
				S_DIVW: if (stat.div_done) state_q <= S_QMULW;
				S_QMULW: if (stat.mul_done) begin
					// remainder zero ends the run; step already taken
					if (stat.rem_zero) state_q <= S_MULW;
					else begin
						div_pend_q <= 1'b1;
						state_q <= S_DIVW;
					end
				end
				S_MULW: state_q <= S_PRODW;
				S_PRODW: if (stat.mul_done) state_q <= S_MODW;
				S_MODW: if (stat.div_done) begin
					if (stat.accept) state_q <= S_BITW;
					else if (idx_q == 4'(CandCount - 1)) begin
						out_data <= 96'(ST_NONE);
						out_valid <= 1'b1;
						state_q <= S_OUT;
					end else begin
						idx_q <= idx_q + 1'b1;
						state_q <= S_CAND;
					end
				end
				S_BITW: if (stat.bits_done) begin
					out_data <= {1'b0, d_bits, e_bits, 64'(d_val), e_val, ST_FOUND};
					out_valid <= 1'b1;
					state_q <= S_OUT;
				end
				S_OUT: if (out_ready) begin
					out_valid <= 1'b0;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> state_q == S_OUT) else $error("valid outside output state");
	assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid) else $error("input taken while result pending");
	assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= 4'(CandCount - 1)) else $error("candidate index out of range");
endmodule

// ----- src/rsa_exponent_pair_search.sv -----
// Top level of the RSA exponent pair search.
//  channel | dir | contents
//  s_axis  | in  | tdata[63:0] phi_value
//  m_axis  | out | tdata status, public_exponent, private_exponent, bit lengths
// One item at a time. Each Euclid step runs the bit-serial divider, then a multiply
// over 16-bit digits; the mod-phi check per candidate runs a multiply, then the divider.
// An accepted candidate ends with the bit length count. Reset clears control state
// and the output register only. The result waits in the output register and
// the input stays blocked until it is taken.
`timescale 1ns / 1ps
module rsa_exponent_pair_search import rsa_pkg::*; #(
	parameter int WordBits = WordBitsDef,
	parameter int CandCount = CandCountDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,  // phi_value
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// status[1:0], public_exponent[18:2], private_exponent[82:19],
	// public_bits[87:83], private_bits[94:88], zero [95]
	output logic [95:0] m_axis_tdata
);
	cmd_t cmd;
	logic [3:0] cand_idx;
	dp_status_t stat;
	logic [16:0] e_val;
	logic [WordBits-1:0] d_val;
	logic [4:0] e_bits;
	logic [6:0] d_bits;

	rsa_datapath #(.WordBits(WordBits)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .cand_idx(cand_idx),
		.phi_in(s_axis_tdata), .stat(stat), .e_out(e_val), .d_out(d_val),
		.e_bits(e_bits), .d_bits(d_bits)
	);

	rsa_ctrl #(.WordBits(WordBits), .CandCount(CandCount)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready), .out_ready(m_axis_tready),
		.out_valid(m_axis_tvalid), .out_data(m_axis_tdata), .cmd(cmd),
		.cand_idx(cand_idx), .stat(stat), .e_val(e_val), .d_val(d_val),
		.e_bits(e_bits), .d_bits(d_bits)
	);
endmodule
